FILE: rtl/button_press_mode_selector_defines.svh
// Assertion macros for the button press mode selector.
`ifndef BUTTON_PRESS_MODE_SELECTOR_DEFINES_SVH
`define BUTTON_PRESS_MODE_SELECTOR_DEFINES_SVH

`ifndef SYNTHESIS
`define BPMS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BPMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BPMS_ASSERT_IMPLY(label, ante, cons, msg)
`define BPMS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: rtl/bpms_pkg.sv
// Shared widths, mode codes and register indexes of the button press mode selector.
`default_nettype none

package bpms_pkg;

    localparam int TS_W       = 24;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    typedef logic [TS_W-1:0]       ts_t;
    typedef logic [MODE_W-1:0]     mode_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    localparam mode_t PWR_OFF   = 2'd0;
    localparam mode_t PWR_IDLE  = 2'd1;
    localparam mode_t PWR_RUN   = 2'd2;
    localparam mode_t PWR_OTHER = 2'd3;

    localparam cfg_idx_t REG_DEBOUNCE   = 2'd0;
    localparam cfg_idx_t REG_LONG_PRESS = 2'd1;

    localparam cfg_data_t DEBOUNCE_RESET   = 24'd330;
    localparam cfg_data_t LONG_PRESS_RESET = 24'd32768;

endpackage

`default_nettype wire

FILE: rtl/bpms_ifs.sv
// Valid/ready channel interfaces for button edges, mode requests and register writes.
`default_nettype none

interface bpms_edge_if;
    import bpms_pkg::*;
    logic  valid;
    logic  ready;
    logic  is_press;
    ts_t   now_ticks;
    mode_t present_mode;

    modport source (output valid, output is_press, output now_ticks,
                    output present_mode, input ready);
    modport sink   (input valid, input is_press, input now_ticks,
                    input present_mode, output ready);
endinterface

interface bpms_result_if;
    import bpms_pkg::*;
    logic  valid;
    logic  ready;
    logic  bounce_rejected;
    logic  request_valid;
    mode_t requested_mode;

    modport source (output valid, output bounce_rejected, output request_valid,
                    output requested_mode, input ready);
    modport sink   (input valid, input bounce_rejected, input request_valid,
                    input requested_mode, output ready);
endinterface

interface bpms_cfg_if;
    import bpms_pkg::*;
    logic      valid;
    logic      ready;
    cfg_idx_t  index;
    cfg_data_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/button_press_mode_selector.sv
// Power-button edge debounce and short/long press mode request generator.
//
// Usage:
//   btn_in  - one transaction per pin edge: is_press, 24-bit tick stamp, current mode.
//   res_out - one transaction per edge: bounce_rejected, request_valid, requested_mode.
//   cfg     - register writes; index 0 debounce_ticks, index 1 long_press_ticks.
//             Always ready; unknown indexes are dropped. Write only while idle.
// Pipeline: an accepted edge passes the input register and then the result
// register (two register stages) before it is offered on res_out.
// Throughput: one edge per cycle unless res_out is held; the combinational path is
// one subtract and one compare per check against the stored edge and press times.
// Reset: both stages empty, edge and press times zero, debounce 330 ticks,
// long press 32768 ticks.
// Stall: while res_out is held, the result register keeps its transaction and
// the input register still takes one more edge; btn_in.ready then drops
// until the result is taken.
`default_nettype none

module button_press_mode_selector #(
    parameter int TICK_BITS = 24
) (
    input  wire            clk,
    input  wire            rst_n,
    bpms_edge_if.sink      btn_in,
    bpms_result_if.source  res_out,
    bpms_cfg_if.sink       cfg
);
    import bpms_pkg::*;

    `include "button_press_mode_selector_defines.svh"

    localparam int CMP_W = (TICK_BITS > CFG_DATA_W) ? TICK_BITS : CFG_DATA_W;

    typedef logic [TICK_BITS-1:0] tick_t;
    typedef logic [CMP_W-1:0]     cmp_t;

    cfg_data_t debounce_reg;
    cfg_data_t long_press_reg;
    tick_t     last_edge_reg;
    tick_t     press_reg;

    logic      s1_vld_reg;
    logic      s1_press_reg;
    tick_t     s1_now_reg;
    mode_t     s1_mode_reg;

    logic      out_vld_reg;
    logic      out_rej_reg;
    logic      out_req_reg;
    mode_t     out_mode_reg;

    logic      out_adv;
    logic      s1_adv;
    logic      in_acc;
    tick_t     gap;
    tick_t     hold;
    logic      rejected_next;
    logic      long_hold;
    logic      req_next;
    mode_t     mode_next;

    assign out_adv = !out_vld_reg || res_out.ready;
    assign s1_adv  = s1_vld_reg && out_adv;
    assign btn_in.ready = !s1_vld_reg || out_adv;
    assign in_acc  = btn_in.valid && btn_in.ready;
    assign cfg.ready = 1'b1;

    assign gap  = s1_now_reg - last_edge_reg;
    assign hold = s1_now_reg - press_reg;
    assign rejected_next = cmp_t'(gap) <= cmp_t'(debounce_reg);
    assign long_hold     = cmp_t'(hold) > cmp_t'(long_press_reg);

    always_comb
    begin
        req_next  = 1'b0;
        mode_next = PWR_OFF;
        if (!rejected_next && !s1_press_reg)
        begin
            if (long_hold)
            begin
                req_next  = 1'b1;
                mode_next = (s1_mode_reg == PWR_OFF) ? PWR_IDLE : PWR_OFF;
            end
            else
            begin
                case (s1_mode_reg)
                    PWR_RUN:
                    begin
                        req_next  = 1'b1;
                        mode_next = PWR_IDLE;
                    end
                    PWR_IDLE:
                    begin
                        req_next  = 1'b1;
                        mode_next = PWR_RUN;
                    end
                    default:
                    begin
                        req_next  = 1'b0;
                        mode_next = PWR_OFF;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RESET;
            long_press_reg <= LONG_PRESS_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_DEBOUNCE:   debounce_reg   <= cfg.data;
                REG_LONG_PRESS: long_press_reg <= cfg.data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
            last_edge_reg <= '0;
            press_reg     <= '0;
        end
        else
        begin
            if (btn_in.ready)
            begin
                s1_vld_reg <= btn_in.valid;
            end
            if (out_adv)
            begin
                out_vld_reg <= s1_vld_reg;
            end
            if (s1_adv)
            begin
                last_edge_reg <= s1_now_reg;
                if (!rejected_next && s1_press_reg)
                begin
                    press_reg <= s1_now_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_press_reg <= btn_in.is_press;
            s1_now_reg   <= tick_t'(btn_in.now_ticks);
            s1_mode_reg  <= btn_in.present_mode;
        end
        if (s1_adv)
        begin
            out_rej_reg  <= rejected_next;
            out_req_reg  <= req_next;
            out_mode_reg <= mode_next;
        end
    end

    assign res_out.valid           = out_vld_reg;
    assign res_out.bounce_rejected = out_rej_reg;
    assign res_out.request_valid   = out_req_reg;
    assign res_out.requested_mode  = out_mode_reg;

    // Check the decision logic and the edge-time update.
    `BPMS_ASSERT_IMPLY(a_bounce_no_request, out_vld_reg && out_rej_reg, !out_req_reg,
        "bounced edge raised a mode request")
    `BPMS_ASSERT_IMPLY(a_no_request_mode_off, out_vld_reg && !out_req_reg,
        out_mode_reg == PWR_OFF, "mode field set without a request")
    `BPMS_ASSERT_IMPLY(a_request_mode_legal, out_vld_reg && out_req_reg,
        out_mode_reg != PWR_OTHER, "request for an undefined mode")
    `BPMS_ASSERT_NEXT(a_edge_time_update, s1_adv, last_edge_reg == $past(s1_now_reg),
        "previous edge time not updated")

endmodule

`default_nettype wire
